/* design/permutation_rank_codec_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the permutation rank codec
// Short forms for the concurrent checks that the codec files use. Each macro
// samples on the rising edge of clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PERMUTATION_RANK_CODEC_MACROS_SVH
`define PERMUTATION_RANK_CODEC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/prc_pkg.sv */
// ---------------------------------------------------------------------------
// Permutation rank codec package
// Widths, default sizes, codes and shared types of the codec.
// ---------------------------------------------------------------------------
package prc_pkg;

    localparam int MAX_LENGTH_DEF     = 10;
    localparam int CODE_W             = 22;
    localparam int ELEM_W             = 8;
    localparam int IDX_W              = 4;
    localparam int LEN_W              = 4;
    localparam logic [LEN_W-1:0] LENGTH_RESET = 4'd10;

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = CODE_W / DIV_BITS_PER_CYCLE;

    localparam logic KIND_ENC  = 1'b0;
    localparam logic KIND_DEC  = 1'b1;
    localparam logic RES_CODE  = 1'b0;
    localparam logic RES_INDEX = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_DIV,
        ST_ROT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_ROTATE,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] from;
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] moved;
    } order_ctl_t;

endpackage

/* design/permutation_rank_codec.sv */
// ---------------------------------------------------------------------------
// Permutation rank codec
// Converts permutations to their inversion code and codes back to index
// orders, one item at a time.
// ---------------------------------------------------------------------------
// An encode item (kind 0) brings one element; it is accepted while idle and
// folded into the running code in the next cycle, the block then being ready
// again, except that the fold of a finishing item waits for a free output
// register. Only the item that completes a permutation of perm_length
// elements yields a result: the finished code, flagged last. A decode item
// (kind 1) brings a code and yields perm_length indices, the final one flagged
// last. Its digits come from the divider, which retires two quotient bits a
// cycle and peels one digit per pass, followed by a rotation step of the
// order cells. Results leave through an output register, so the next item
// is taken while a result still waits. The length register may be written
// while the block is idle; a write abandons any encode in progress.
// Lengths outside 1 to MAX_LENGTH are saturated into that range.
// ---------------------------------------------------------------------------
`include "permutation_rank_codec_macros.svh"

module permutation_rank_codec
    import prc_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Length register write channel.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data,
    // Input items.
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [ELEM_W-1:0] element_in,
    input  logic [CODE_W-1:0] code_in,
    // Result items.
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result_kind,
    output logic [CODE_W-1:0] code_out,
    output logic [IDX_W-1:0]  element_out,
    output logic              last
);

    // CNT_W holds counts up to the length itself; POS_W addresses one cell.
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int POS_W = $clog2(MAX_LENGTH);

    state_t state_reg;
    state_t state_next;

    logic [LEN_W-1:0]  perm_length_reg;
    logic [CNT_W-1:0]  element_count_reg;
    logic [CODE_W-1:0] running_code_reg;
    logic [CNT_W-1:0]  step_reg;
    logic [ELEM_W-1:0] elem_reg;

    logic              out_valid_reg;
    logic              result_kind_reg;
    logic [CODE_W-1:0] code_out_reg;
    logic [IDX_W-1:0]  element_out_reg;
    logic              last_reg;

    logic              out_free;
    logic              out_load;
    logic              res_kind_next;
    logic [CODE_W-1:0] res_code_next;
    logic [IDX_W-1:0]  res_elem_next;
    logic              res_last_next;

    logic [CNT_W-1:0]  len_eff;
    logic              in_accept;
    logic              cfg_write;

    // Encode path.
    logic [ELEM_W-1:0]     seen_chain [MAX_LENGTH];
    logic [MAX_LENGTH-1:0] seen_gt;
    logic                  seen_shift;
    logic                  enc_commit;
    logic [CNT_W-1:0]      enc_pos;
    logic [CNT_W-1:0]      enc_pos_plus1;
    logic [CODE_W-1:0]     enc_base;
    logic [CNT_W-1:0]      enc_greater;
    logic [CODE_W+CNT_W-1:0] enc_prod;
    logic [CODE_W-1:0]     enc_code_next;
    logic                  enc_done;

    // Decode path.
    logic [IDX_W-1:0]  order_entry [MAX_LENGTH];
    order_ctl_t        order_ctl;
    logic              div_start;
    logic [CODE_W-1:0] div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_busy;
    logic              div_last;
    logic [CODE_W-1:0] div_quotient;
    logic [CNT_W-1:0]  div_remainder;
    logic [CNT_W-1:0]  remaining;
    logic [IDX_W-1:0]  rot_top;
    logic [IDX_W-1:0]  rot_from;
    logic              digit_last;
    logic              emit_last;

    // The length register saturates into the supported range.
    always_comb
    begin
        if (perm_length_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (int'(perm_length_reg) > MAX_LENGTH)
        begin
            len_eff = CNT_W'(MAX_LENGTH);
        end
        else
        begin
            len_eff = CNT_W'(perm_length_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Encode: the seen cells form a shift line, the newest element in
    // cell 0. Cells below the current position take part in the count.
    // ------------------------------------------------------------------
    assign enc_pos  = (element_count_reg >= len_eff) ? '0 : element_count_reg;
    assign enc_base = (element_count_reg >= len_eff) ? '0 : running_code_reg;

    for (genvar k = 0; k < MAX_LENGTH; k++)
    begin : g_seen
        logic [ELEM_W-1:0] cell_in;
        logic [ELEM_W-1:0] cell_out;
        if (k == 0)
        begin : g_head
            assign cell_in = elem_reg;
        end
        else
        begin : g_body
            assign cell_in = seen_chain[k-1];
        end
        prc_seen_cell u_cell (
            .clk      (clk),
            .shift_en (seen_shift),
            .data_in  (cell_in),
            .probe    (elem_reg),
            .enable   (CNT_W'(k) < enc_pos),
            .data_out (cell_out),
            .greater  (seen_gt[k])
        );
        assign seen_chain[k] = cell_out;
    end

    assign enc_greater   = CNT_W'($countones(seen_gt));
    assign enc_pos_plus1 = enc_pos + 1'b1;
    assign enc_prod      = enc_base * enc_pos_plus1;
    assign enc_code_next = enc_prod[CODE_W-1:0] + CODE_W'(enc_greater);
    assign enc_done      = (enc_pos_plus1 >= len_eff);

    // ------------------------------------------------------------------
    // Decode: the divider peels one digit per pass and the order cells
    // rotate the selected entry up to the top of the remaining slots.
    // ------------------------------------------------------------------
    prc_divider #(
        .DIV_W (CNT_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .last_step (div_last),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign remaining  = len_eff - step_reg;
    assign rot_top    = IDX_W'(remaining - 1'b1);
    assign rot_from   = rot_top - IDX_W'(div_remainder);
    assign digit_last = ((step_reg + 1'b1) == len_eff);
    assign emit_last  = ((step_reg + 1'b1) == len_eff);

    for (genvar k = 0; k < MAX_LENGTH; k++)
    begin : g_order
        logic [IDX_W-1:0] upper;
        logic [IDX_W-1:0] cell_out;
        if (k == MAX_LENGTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_body
            assign upper = order_entry[k+1];
        end
        prc_order_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk         (clk),
            .ctl         (order_ctl),
            .neighbor_in (upper),
            .entry_out   (cell_out)
        );
        assign order_entry[k] = cell_out;
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (kind == KIND_DEC) ? ST_DIV : ST_ENC;
                end
            end
            ST_ENC:
            begin
                if (!enc_done || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                state_next = digit_last ? ST_EMIT : ST_DIV;
            end
            ST_EMIT:
            begin
                if (out_free && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        seen_shift      = 1'b0;
        enc_commit      = 1'b0;
        div_start       = 1'b0;
        div_dividend    = div_quotient;
        div_divisor     = remaining - 1'b1;
        order_ctl.op    = OP_HOLD;
        order_ctl.from  = rot_from;
        order_ctl.top   = rot_top;
        order_ctl.moved = order_entry[rot_from[POS_W-1:0]];
        out_load        = 1'b0;
        res_kind_next   = RES_CODE;
        res_code_next   = enc_code_next;
        res_elem_next   = '0;
        res_last_next   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (kind == KIND_DEC))
                begin
                    div_start    = 1'b1;
                    div_dividend = code_in;
                    div_divisor  = len_eff;
                    order_ctl.op = OP_LOAD;
                end
            end
            ST_ENC:
            begin
                if (!enc_done || out_free)
                begin
                    seen_shift = 1'b1;
                    enc_commit = 1'b1;
                    out_load   = enc_done;
                end
            end
            ST_DIV:
            begin
                order_ctl.op = OP_HOLD;
            end
            ST_ROT:
            begin
                order_ctl.op = OP_ROTATE;
                div_start    = !digit_last;
            end
            ST_EMIT:
            begin
                res_kind_next = RES_INDEX;
                res_code_next = '0;
                res_elem_next = order_entry[0];
                res_last_next = emit_last;
                if (out_free)
                begin
                    out_load     = 1'b1;
                    order_ctl.op = OP_SHIFT;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            perm_length_reg   <= LENGTH_RESET;
            element_count_reg <= '0;
            running_code_reg  <= '0;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // A length write abandons the encode in progress.
            if (cfg_write)
            begin
                perm_length_reg   <= cfg_data;
                element_count_reg <= '0;
                running_code_reg  <= '0;
            end
            else if (enc_commit)
            begin
                element_count_reg <= enc_done ? '0 : enc_pos_plus1;
                running_code_reg  <= enc_done ? '0 : enc_code_next;
            end

            if (in_accept)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_ROT)
            begin
                step_reg <= digit_last ? '0 : step_reg + 1'b1;
            end
            else if (out_load && (state_reg == ST_EMIT))
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            elem_reg <= element_in;
        end
        if (out_load)
        begin
            result_kind_reg <= res_kind_next;
            code_out_reg    <= res_code_next;
            element_out_reg <= res_elem_next;
            last_reg        <= res_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign code_out    = code_out_reg;
    assign element_out = element_out_reg;
    assign last        = last_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `PRC_ASSERT_NOW(a_count_below_length, 1'b1, element_count_reg < len_eff,
        "encode position reached the length")
    `PRC_ASSERT_NOW(a_divider_busy, state_reg == ST_DIV, div_busy,
        "sequencer waits on an idle divider")
    `PRC_ASSERT_NOW(a_digit_below_radix, state_reg == ST_ROT, div_remainder < remaining,
        "decode digit not below its radix")
    `PRC_ASSERT_NEXT(a_emit_ends, (state_reg == ST_EMIT) && out_load && emit_last,
        state_reg == ST_IDLE, "decode did not end after its last index")

endmodule

/* design/prc_seen_cell.sv */
// ---------------------------------------------------------------------------
// Seen element cell
// Holds one earlier element of the permutation being encoded, passes it on
// to its neighbor when a new element enters, and compares it with that one.
// ---------------------------------------------------------------------------
module prc_seen_cell
    import prc_pkg::*;
(
    input  logic              clk,
    input  logic              shift_en,
    input  logic [ELEM_W-1:0] data_in,
    input  logic [ELEM_W-1:0] probe,
    input  logic              enable,
    output logic [ELEM_W-1:0] data_out,
    output logic              greater
);

    logic [ELEM_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;
    assign greater  = enable && (probe < data_reg);

endmodule

/* design/prc_order_cell.sv */
// ---------------------------------------------------------------------------
// Decode order cell
// Holds one slot of the decode working order and takes its identity value,
// its upper neighbor or the moved entry as the sequencer commands.
// ---------------------------------------------------------------------------
module prc_order_cell
    import prc_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic             clk,
    input  order_ctl_t       ctl,
    input  logic [IDX_W-1:0] neighbor_in,
    output logic [IDX_W-1:0] entry_out
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

    logic [IDX_W-1:0] entry_reg;
    logic [IDX_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            OP_LOAD:   entry_next = MY_INDEX;
            OP_SHIFT:  entry_next = neighbor_in;
            OP_ROTATE:
            begin
                if (MY_INDEX == ctl.top)
                begin
                    entry_next = ctl.moved;
                end
                else if ((MY_INDEX >= ctl.from) && (MY_INDEX < ctl.top))
                begin
                    entry_next = neighbor_in;
                end
            end
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule

/* design/prc_divider.sv */
// ---------------------------------------------------------------------------
// Iterative code divider
// Restoring division of the code by a small radix, two quotient bits per
// cycle; quotient and remainder are final once the count runs out.
// ---------------------------------------------------------------------------
module prc_divider
    import prc_pkg::*;
#(
    parameter int DIV_W = LEN_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CODE_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              busy,
    output logic              last_step,
    output logic [CODE_W-1:0] quotient,
    output logic [DIV_W-1:0]  remainder
);

    localparam int DC_W = $clog2(DIV_CYCLES + 1);

    logic [DC_W-1:0]   cnt_reg;
    logic [DC_W-1:0]   cnt_next;
    logic [CODE_W-1:0] quo_reg;
    logic [CODE_W-1:0] quo_next;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W-1:0]  den_reg;

    always_comb
    begin
        logic [CODE_W-1:0] q;
        logic [DIV_W-1:0]  r;
        logic [DIV_W:0]    part;
        q    = quo_reg;
        r    = rem_reg;
        part = '0;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++)
        begin
            part = {r, q[CODE_W-1]};
            q    = {q[CODE_W-2:0], 1'b0};
            if (part >= {1'b0, den_reg})
            begin
                r    = DIV_W'(part - {1'b0, den_reg});
                q[0] = 1'b1;
            end
            else
            begin
                r = part[DIV_W-1:0];
            end
        end
        quo_next = q;
        rem_next = r;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = DC_W'(DIV_CYCLES);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign last_step = (cnt_reg == DC_W'(1));
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* tb/tb_permutation_rank_codec.sv */
// ---------------------------------------------------------------------------
// Testbench for the permutation rank codec
// Sends encode elements, decode codes and length register writes. It predicts
// every finished code and every decoded index, and compares each result item
// with the oldest prediction, field by field, under random idling on both
// channels.
// ---------------------------------------------------------------------------
module tb_permutation_rank_codec;

    import prc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int RESET_CYCLES   = 4;
    localparam int MAX_LEN        = MAX_LENGTH_DEF;
    // An encode item keeps the block busy through its accept and fold. This margin
    // covers that before a length write that follows encode items with no result.
    localparam int SETTLE_CYCLES  = 16;
    // The final drain outlasts a decode at full length, to catch stray result items.
    localparam int DRAIN_CYCLES   = 150;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int RANDOM_PHASES  = 14;
    localparam int ITEMS_PER_PHASE = 26;

    // One entry of the stimulus plan: either an input item or a length write.
    typedef struct packed {
        logic              is_cfg;
        logic [LEN_W-1:0]  len;
        logic              kind;
        logic [ELEM_W-1:0] elem;
        logic [CODE_W-1:0] code;
    } stim_t;

    typedef struct packed {
        logic              rk;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } codec_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              kind = KIND_ENC;
    logic [ELEM_W-1:0] element_in = '0;
    logic [CODE_W-1:0] code_in = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              result_kind;
    logic [CODE_W-1:0] code_out;
    logic [IDX_W-1:0]  element_out;
    logic              last;

    permutation_rank_codec dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .element_in  (element_in),
        .code_in     (code_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .code_out    (code_out),
        .element_out (element_out),
        .last        (last)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Pending stimulus, filled once at the start, and the predicted results
    // that still have to come out of the block, oldest first.
    stim_t         items_to_send[$];
    codec_result_t awaited_results[$];

    // Our own copy of the codec state: the length register, the elements of
    // the permutation being encoded and its partial code.
    logic [LEN_W-1:0]  perm_len = LENGTH_RESET;
    logic [ELEM_W-1:0] seen_elems [MAX_LEN];
    int unsigned       elems_seen = 0;
    logic [CODE_W-1:0] partial_code = '0;

    // Handshake bookkeeping shared by the driver and the monitor. The monitor
    // sets the taken flags at the rising edge; the driver clears them at the
    // following falling edge.
    bit item_pending = 1'b0;
    bit cfg_pending  = 1'b0;
    bit item_taken   = 1'b0;
    bit cfg_taken    = 1'b0;
    bit result_taken = 1'b0;
    int send_gap     = 0;
    int hold_ready   = 0;
    bit send_burst   = 1'b0;
    bit recv_burst   = 1'b0;
    int idle_cycles  = 0;
    int errors       = 0;
    stim_t head;

    // Lengths outside 1 to MAX_LEN are saturated into that range.
    function automatic int clamp_length(logic [LEN_W-1:0] l);
        if (l < 1)
            return 1;
        if (l > MAX_LEN)
            return MAX_LEN;
        return int'(l);
    endfunction

    // Encode step: count the earlier elements strictly greater than the new
    // one and fold that count into the mixed-radix code.
    function automatic void fold_element(logic [ELEM_W-1:0] e);
        int unsigned     pos;
        int unsigned     greater;
        int              eff;
        longint unsigned wide;
        codec_result_t   r;
        eff = clamp_length(perm_len);
        pos = elems_seen;
        greater = 0;
        if (pos >= eff)
        begin
            pos = 0;
            partial_code = '0;
        end
        for (int j = 0; j < pos; j++)
            if (e < seen_elems[j])
                greater++;
        seen_elems[pos] = e;
        wide = longint'(partial_code) * (pos + 1) + greater;
        partial_code = wide[CODE_W-1:0];
        pos++;
        if (pos >= eff)
        begin
            r = '{rk: RES_CODE, code: partial_code, idx: '0, last: 1'b1};
            awaited_results.push_back(r);
            elems_seen = 0;
            partial_code = '0;
        end
        else
            elems_seen = pos;
    endfunction

    // Decode: start from the identity order and peel one digit per slot,
    // rotating the chosen entry up to the top of the shrinking range.
    function automatic void unrank_code(logic [CODE_W-1:0] c);
        logic [IDX_W-1:0] order [MAX_LEN];
        logic [IDX_W-1:0] moved;
        int unsigned      rest;
        int unsigned      remaining;
        int unsigned      top;
        int unsigned      src;
        int               eff;
        codec_result_t    r;
        eff = clamp_length(perm_len);
        rest = c;
        for (int i = 0; i < eff; i++)
            order[i] = IDX_W'(i);
        for (int i = 0; i < eff; i++)
        begin
            remaining = eff - i;
            top = remaining - 1;
            src = top - (rest % remaining);
            rest = rest / remaining;
            moved = order[src];
            for (int j = src; j < top; j++)
                order[j] = order[j + 1];
            order[top] = moved;
        end
        for (int i = 0; i < eff; i++)
        begin
            r = '{rk: RES_INDEX, code: '0, idx: order[i], last: (i + 1 == eff)};
            awaited_results.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(string what, longint unsigned want,
                                            longint unsigned got);
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function automatic void check_result();
        codec_result_t want;
        if (awaited_results.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result item: expected none, %s %0d %0d %0d %0d",
                     $time, "actual kind, code, index, last:",
                     result_kind, code_out, element_out, last);
            return;
        end
        want = awaited_results.pop_front();
        if (result_kind !== want.rk)
            report_mismatch("result_kind", want.rk, result_kind);
        if (code_out !== want.code)
            report_mismatch("code_out", want.code, code_out);
        if (element_out !== want.idx)
            report_mismatch("element_out", want.idx, element_out);
        if (last !== want.last)
            report_mismatch("last", want.last, last);
    endfunction

    task automatic push_item(logic k, logic [ELEM_W-1:0] e, logic [CODE_W-1:0] c);
        stim_t s;
        s = '{is_cfg: 1'b0, len: '0, kind: k, elem: e, code: c};
        items_to_send.push_back(s);
    endtask

    task automatic push_length(logic [LEN_W-1:0] l);
        stim_t s;
        s = '{is_cfg: 1'b1, len: l, kind: KIND_ENC, elem: '0, code: '0};
        items_to_send.push_back(s);
    endtask

    // Monitor: all handshakes are sampled at the rising edge, before the
    // block updates its registers. Accepted input items go straight into the
    // predictor, accepted result items are checked against it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_result();
                result_taken = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                if (kind == KIND_ENC)
                    fold_element(element_in);
                else
                    unrank_code(code_in);
                item_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                // A length write also abandons any encode in progress.
                perm_len = cfg_data;
                elems_seen = 0;
                partial_code = '0;
                cfg_taken = 1'b1;
            end
            if (item_pending || cfg_pending || out_valid || awaited_results.size() != 0)
                idle_cycles = 0;
            else if (idle_cycles < SETTLE_CYCLES)
                idle_cycles++;
        end
    end

    // Driver and receiver: every input changes at the falling edge, and each
    // signal gets at most one nonblocking assignment per edge, so valid stays
    // high across back-to-back items.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_taken)
            begin
                item_taken = 1'b0;
                item_pending = 1'b0;
            end
            if (cfg_taken)
            begin
                cfg_taken = 1'b0;
                cfg_pending = 1'b0;
            end
            if (!item_pending && !cfg_pending)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (items_to_send.size() > 0)
                begin
                    head = items_to_send[0];
                    if (!head.is_cfg)
                    begin
                        kind <= head.kind;
                        element_in <= head.elem;
                        code_in <= head.code;
                        item_pending = 1'b1;
                        void'(items_to_send.pop_front());
                        // Now and then switch between random gaps and a burst
                        // with no gaps at all.
                        if ($urandom_range(0, 29) == 0)
                            send_burst = !send_burst;
                        send_gap = send_burst ? 0 : $urandom_range(0, 15);
                    end
                    else if (awaited_results.size() == 0 && idle_cycles >= SETTLE_CYCLES)
                    begin
                        // The length is only written once the block has
                        // drained every result and had time to settle.
                        cfg_data <= head.len;
                        cfg_pending = 1'b1;
                        void'(items_to_send.pop_front());
                    end
                end
            end
            in_valid <= item_pending;
            cfg_valid <= cfg_pending;

            if (result_taken)
            begin
                result_taken = 1'b0;
                if ($urandom_range(0, 29) == 0)
                    recv_burst = !recv_burst;
                hold_ready = recv_burst ? 0 : $urandom_range(0, 15);
            end
            else if (out_valid && hold_ready > 0)
                hold_ready--;
            out_ready <= (hold_ready == 0);
        end
    end

    // Stimulus plan and end of run.
    initial
    begin
        int                eff;
        int                fact_len;
        int                added;
        int                pick;
        int                style;
        int                mid;
        int                n;
        int                tmp;
        int                k;
        int                offset;
        int                perm [MAX_LEN];
        logic [LEN_W-1:0]  len;
        logic [ELEM_W-1:0] e;

        // Directed part at the reset length of ten. A strictly decreasing
        // permutation with both element extremes gives the largest code.
        push_item(KIND_ENC, 8'd255, '0);
        push_item(KIND_ENC, 8'd200, '0);
        push_item(KIND_ENC, 8'd150, '0);
        push_item(KIND_ENC, 8'd100, '0);
        push_item(KIND_ENC, 8'd80, '0);
        push_item(KIND_ENC, 8'd60, '0);
        push_item(KIND_ENC, 8'd40, '0);
        push_item(KIND_ENC, 8'd20, '0);
        push_item(KIND_ENC, 8'd10, '0);
        push_item(KIND_ENC, 8'd0, '0);
        // Smallest code, largest in-range code, and an oversized code whose
        // upper digits are dropped.
        push_item(KIND_DEC, '0, 22'd0);
        push_item(KIND_DEC, '0, 22'd3628799);
        push_item(KIND_DEC, '0, {CODE_W{1'b1}});
        // Equal elements only count when strictly greater, and a decode in
        // the middle of an encode leaves its progress alone.
        push_item(KIND_ENC, 8'd7, '0);
        push_item(KIND_ENC, 8'd7, '0);
        push_item(KIND_ENC, 8'd0, '0);
        push_item(KIND_ENC, 8'd255, '0);
        push_item(KIND_ENC, 8'd7, '0);
        push_item(KIND_DEC, '0, 22'd1234567);
        push_item(KIND_ENC, 8'd255, '0);
        push_item(KIND_ENC, 8'd0, '0);
        push_item(KIND_ENC, 8'd7, '0);
        push_item(KIND_ENC, 8'd7, '0);
        push_item(KIND_ENC, 8'd255, '0);
        // A lone element that the first length write abandons.
        push_item(KIND_ENC, 8'd128, '0);

        // Random phases. The first ones cover length one, zero (saturates to
        // one), fifteen (saturates to ten), ten and two; the rest are random.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: len = 4'd1;
                1: len = 4'd0;
                2: len = 4'd15;
                3: len = 4'd10;
                4: len = 4'd2;
                default: len = LEN_W'($urandom_range(0, 15));
            endcase
            push_length(len);
            eff = clamp_length(len);
            fact_len = 1;
            for (k = 2; k <= eff; k++)
                fact_len *= k;
            added = 0;
            while (added < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    // A complete permutation, sometimes with a decode slipped
                    // in partway through.
                    style = $urandom_range(0, 2);
                    mid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : -1;
                    for (k = 0; k < eff; k++)
                        perm[k] = k;
                    for (k = eff - 1; k > 0; k--)
                    begin
                        n = $urandom_range(0, k);
                        tmp = perm[k];
                        perm[k] = perm[n];
                        perm[n] = tmp;
                    end
                    offset = $urandom_range(0, 30);
                    for (k = 0; k < eff; k++)
                    begin
                        if (k == mid)
                        begin
                            push_item(KIND_DEC, '0, CODE_W'($urandom_range(0, fact_len - 1)));
                            added++;
                        end
                        case (style)
                            0: e = ELEM_W'($urandom_range(0, 255));
                            1: e = ELEM_W'($urandom_range(0, 3) * 85);
                            default: e = ELEM_W'(perm[k] * 23 + offset);
                        endcase
                        push_item(KIND_ENC, e, '0);
                        added++;
                    end
                end
                else if (pick < 8)
                begin
                    push_item(KIND_DEC, ELEM_W'($urandom_range(0, 255)),
                              CODE_W'($urandom_range(0, fact_len - 1)));
                    added++;
                end
                else if (pick == 8 || eff == 1)
                begin
                    // Any 22-bit code, mostly beyond the range of lengths below ten.
                    push_item(KIND_DEC, '0, CODE_W'($urandom_range(0, (1 << CODE_W) - 1)));
                    added++;
                end
                else
                begin
                    // A broken encode: too few elements, so the next
                    // permutation starts out of step or a length write
                    // abandons it.
                    n = $urandom_range(1, eff - 1);
                    for (k = 0; k < n; k++)
                        push_item(KIND_ENC, ELEM_W'($urandom_range(0, 255)),
                                  CODE_W'($urandom_range(0, (1 << CODE_W) - 1)));
                    added += n;
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_to_send.size() != 0 || item_pending || cfg_pending
               || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog for a block that hangs or never drains.
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/prc_pkg.sv
design/prc_seen_cell.sv
design/prc_order_cell.sv
design/prc_divider.sv
design/permutation_rank_codec.sv
tb/tb_permutation_rank_codec.sv
